>>> design/sfcf_pkg.sv
// shared types, sizes and helpers for the spill/fill cached fifo
// no dependencies; every design file imports this package
`default_nettype none

package sfcf_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int STORE_DEPTH = 1024;
  localparam int DATA_WIDTH  = 32;

  localparam int QAW = $clog2(QUEUE_DEPTH);
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);
  localparam int SAW = $clog2(STORE_DEPTH);
  localparam int SCW = $clog2(STORE_DEPTH + 1);
  localparam int TW  = $clog2(2 * QUEUE_DEPTH + STORE_DEPTH + 1);

  typedef logic [DATA_WIDTH-1:0] word_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_UNDER = 2'd1,
    ST_DROP  = 2'd2
  } status_t;

  // fill levels of the three stages
  typedef struct packed {
    logic [QCW-1:0] in_cnt;
    logic [QCW-1:0] out_cnt;
    logic [SCW-1:0] st_cnt;
  } lvl_t;

  // strobes from the sequencer to the datapath
  typedef struct packed {
    logic    accept;
    logic    in_push;
    logic    in_pop;
    logic    out_push;
    logic    out_pop;
    logic    st_push;
    logic    st_pop;
    logic    val_from_in;
    logic    val_from_out;
    status_t stat;
    logic    res_load;
  } ctl_t;

  function automatic word_t to_word(input logic [31:0] v);
    logic [63:0] z;
    z = {32'b0, v};
    return z[DATA_WIDTH-1:0];
  endfunction

  // sign-extend from the stored width, then keep 32 bits
  function automatic logic [31:0] to_out(input word_t w);
    logic signed [63:0] e;
    e = 64'(signed'(w));
    return e[31:0];
  endfunction

endpackage

`default_nettype wire

>>> design/spill_fill_cached_fifo_core.sv
// top level of the spill/fill cached fifo: queues, store, sequencer, result register
// depends on sfcf_pkg, sfcf_queue, sfcf_store, sfcf_seq
//
// A three-level fifo. Requests come in on kind/value_in with in_valid and
// in_stall; kind 0 queues value_in, kind 1 removes the oldest value. Every
// request gives one result on value_out, status, total_count, is_empty and
// is_full, qualified by out_valid and held while out_stall is high.
// One request is worked on at a time; in_stall stays high until its result
// is in the output register. An insert into a full input queue first
// spills all of that queue into the store, or is dropped when the store
// lacks room for a queue's worth; a remove takes from the output queue,
// else refills up to QUEUE_DEPTH words into it from the store, else takes
// from the input queue, else reports an underflow.
// Spill and refill move one word a cycle through the store; the store
// read is registered, so each popped word enters the output queue from it.
// A stalled result stays in its register while the next request is
// already accepted; that request then waits for the register to free.
// Reset (rst, synchronous) empties all three levels at once; the word
// stores themselves are not cleared.
`default_nettype none

module spill_fill_cached_fifo_core import sfcf_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               kind,
  input  wire logic signed [31:0] value_in,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      value_out,
  output logic [1:0]              status,
  output logic [10:0]             total_count,
  output logic                    is_empty,
  output logic                    is_full
);

  ctl_t         ctl;
  lvl_t         lvl;
  word_t        req_value;
  word_t        in_rd;
  word_t        out_rd;
  word_t        st_rd;
  logic [31:0]  val;
  status_t      stat;
  logic [TW-1:0] total;
  logic         res_free;

  sfcf_queue u_in_q (
    .clk       (clk),
    .rst       (rst),
    .push      (ctl.in_push),
    .push_data (req_value),
    .pop       (ctl.in_pop),
    .rd_data   (in_rd),
    .count     (lvl.in_cnt)
  );

  sfcf_store u_store (
    .clk       (clk),
    .rst       (rst),
    .push      (ctl.st_push),
    .push_data (in_rd),
    .pop       (ctl.st_pop),
    .rd_data   (st_rd),
    .count     (lvl.st_cnt)
  );

  sfcf_queue u_out_q (
    .clk       (clk),
    .rst       (rst),
    .push      (ctl.out_push),
    .push_data (st_rd),
    .pop       (ctl.out_pop),
    .rd_data   (out_rd),
    .count     (lvl.out_cnt)
  );

  assign res_free = !out_valid || !out_stall;

  sfcf_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .kind     (kind),
    .lvl      (lvl),
    .res_free (res_free),
    .in_stall (in_stall),
    .ctl      (ctl)
  );

  // request word and step result held until the output register loads
  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      req_value <= to_word(value_in);
      stat      <= ctl.stat;
    end
    if (ctl.val_from_in) val <= to_out(in_rd);
    else if (ctl.val_from_out) val <= to_out(out_rd);
    else if (ctl.accept) val <= '0;
  end

  assign total = TW'(lvl.in_cnt) + TW'(lvl.out_cnt) + TW'(lvl.st_cnt);

  always_ff @(posedge clk) begin
    if (ctl.res_load) begin
      value_out   <= val;
      status      <= stat;
      total_count <= 11'(total);
      is_empty    <= (total == '0);
      is_full     <= (lvl.in_cnt == QCW'(QUEUE_DEPTH)) &&
                     (lvl.out_cnt == QCW'(QUEUE_DEPTH));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.res_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request accepted without going busy");

  a_under_empty: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_UNDER) |-> (is_empty && total_count == 11'd0))
    else $error("underflow reported while data held");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_OK) |-> (value_out == 32'sd0))
    else $error("failed request returned a value");

  a_drop_full: assert property (@(posedge clk) disable iff (rst)
    (ctl.accept && ctl.stat == ST_DROP) |-> (lvl.in_cnt == QCW'(QUEUE_DEPTH)))
    else $error("insert dropped with input queue not full");

endmodule

`default_nettype wire

>>> design/sfcf_queue.sv
// small ring queue of QUEUE_DEPTH words with read, write and count
// depends on sfcf_pkg
`default_nettype none

module sfcf_queue import sfcf_pkg::*; (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire word_t          push_data,
  input  wire logic           pop,
  output word_t               rd_data,
  output logic [QCW-1:0]      count
);

  word_t          mem [QUEUE_DEPTH];
  logic [QAW-1:0] rd;
  logic [QAW-1:0] wr;

  function automatic logic [QAW-1:0] adv(input logic [QAW-1:0] p);
    return (p == QAW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr] <= push_data;
    end
  end

  assign rd_data = mem[rd];

  always_ff @(posedge clk) begin
    if (rst) begin
      rd    <= '0;
      wr    <= '0;
      count <= '0;
    end else begin
      if (push) wr <= adv(wr);
      if (pop) rd <= adv(rd);
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

`default_nettype wire

>>> design/sfcf_store.sv
// backing store: STORE_DEPTH-word ring in a memory with registered read
// depends on sfcf_pkg
`default_nettype none

module sfcf_store import sfcf_pkg::*; (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire word_t          push_data,
  input  wire logic           pop,
  output word_t               rd_data,
  output logic [SCW-1:0]      count
);

  word_t          mem [STORE_DEPTH];
  logic [SAW-1:0] rd;
  logic [SAW-1:0] wr;

  function automatic logic [SAW-1:0] adv(input logic [SAW-1:0] p);
    return (p == SAW'(STORE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // data of a pop is registered and shows up in the cycle after the pop
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr] <= push_data;
    end
    if (pop) begin
      rd_data <= mem[rd];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd    <= '0;
      wr    <= '0;
      count <= '0;
    end else begin
      if (push) wr <= adv(wr);
      if (pop) rd <= adv(rd);
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

`default_nettype wire

>>> design/sfcf_seq.sv
// sequencer: decides each request and steps spill and refill one word a cycle
// depends on sfcf_pkg
`default_nettype none

module sfcf_seq import sfcf_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  input  wire logic  kind,
  input  wire lvl_t  lvl,
  input  wire logic  res_free,
  output logic       in_stall,
  output ctl_t       ctl
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_INS    = 6'b000010,
    S_SPILL  = 6'b000100,
    S_FILL   = 6'b001000,
    S_TAKE   = 6'b010000,
    S_FINISH = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;
  logic   pending;
  logic   pending_next;
  logic   in_full;
  logic   no_room;
  logic   fill_more;

  assign in_full   = (lvl.in_cnt == QCW'(QUEUE_DEPTH));
  assign no_room   = (STORE_DEPTH - int'(lvl.st_cnt)) < QUEUE_DEPTH;
  // words already in the output queue plus the one arriving from the store
  assign fill_more = (lvl.st_cnt != '0) &&
                     (({1'b0, lvl.out_cnt} + (QCW + 1)'(pending)) <
                      (QCW + 1)'(QUEUE_DEPTH));

  assign in_stall = (state != S_IDLE);

  always_comb begin
    ctl          = '0;
    ctl.stat     = ST_OK;
    state_next   = state;
    pending_next = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctl.accept = 1'b1;
          if (!kind) begin
            if (in_full && no_room) begin
              ctl.stat   = ST_DROP;
              state_next = S_FINISH;
            end else if (in_full) begin
              state_next = S_SPILL;
            end else begin
              state_next = S_INS;
            end
          end else if (lvl.out_cnt != '0) begin
            ctl.out_pop      = 1'b1;
            ctl.val_from_out = 1'b1;
            state_next       = S_FINISH;
          end else if (lvl.st_cnt != '0) begin
            state_next = S_FILL;
          end else if (lvl.in_cnt != '0) begin
            ctl.in_pop      = 1'b1;
            ctl.val_from_in = 1'b1;
            state_next      = S_FINISH;
          end else begin
            ctl.stat   = ST_UNDER;
            state_next = S_FINISH;
          end
        end
      end
      S_INS: begin
        ctl.in_push = 1'b1;
        state_next  = S_FINISH;
      end
      S_SPILL: begin
        if (lvl.in_cnt != '0) begin
          ctl.in_pop  = 1'b1;
          ctl.st_push = 1'b1;
        end else begin
          state_next = S_INS;
        end
      end
      S_FILL: begin
        ctl.out_push = pending;
        ctl.st_pop   = fill_more;
        pending_next = fill_more;
        if (!fill_more && !pending) begin
          state_next = S_TAKE;
        end
      end
      S_TAKE: begin
        ctl.out_pop      = 1'b1;
        ctl.val_from_out = 1'b1;
        state_next       = S_FINISH;
      end
      S_FINISH: begin
        if (res_free) begin
          ctl.res_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      pending <= 1'b0;
    end else begin
      state   <= state_next;
      pending <= pending_next;
    end
  end

endmodule

`default_nettype wire

>>> tb/sv/tb_spill_fill_cached_fifo_core.sv
// self-checking testbench for spill_fill_cached_fifo_core
// depends on sfcf_pkg and the design; a scoreboard class predicts every result
`timescale 1ns / 100ps

module tb_spill_fill_cached_fifo_core;
  import sfcf_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int MAX_REPORTS    = 10;

  typedef struct packed {
    logic [31:0] value;
    status_t     stat;
    logic [10:0] total;
    logic        empty;
    logic        full;
  } fifo_result_t;

  class fifo_scoreboard;
    logic [31:0]  in_words[$];
    logic [31:0]  store_words[$];
    logic [31:0]  out_words[$];
    fifo_result_t pending_results[$];
    int unsigned  requests, spills, refills, drops, underflows, mismatches;

    function int unsigned level();
      return in_words.size() + store_words.size() + out_words.size();
    endfunction

    function int unsigned pending();
      return pending_results.size();
    endfunction

    // work out the result of an accepted request and queue it
    function void note_request(bit op_remove, logic [31:0] word);
      fifo_result_t r;
      int unsigned  tot;
      r.value = '0;
      r.stat  = ST_OK;
      requests++;
      if (!op_remove) begin
        if (in_words.size() >= QUEUE_DEPTH &&
            STORE_DEPTH - store_words.size() < QUEUE_DEPTH) begin
          r.stat = ST_DROP;
          drops++;
        end else begin
          if (in_words.size() >= QUEUE_DEPTH) begin
            while (in_words.size() > 0) store_words.push_back(in_words.pop_front());
            spills++;
          end
          in_words.push_back(word);
        end
      end else begin
        if (out_words.size() > 0) begin
          r.value = out_words.pop_front();
        end else if (store_words.size() > 0) begin
          while (out_words.size() < QUEUE_DEPTH && store_words.size() > 0)
            out_words.push_back(store_words.pop_front());
          refills++;
          r.value = out_words.pop_front();
        end else if (in_words.size() > 0) begin
          r.value = in_words.pop_front();
        end else begin
          r.stat = ST_UNDER;
          underflows++;
        end
      end
      tot     = level();
      r.total = tot[10:0];
      r.empty = (tot == 0);
      r.full  = (in_words.size() >= QUEUE_DEPTH) && (out_words.size() >= QUEUE_DEPTH);
      pending_results.push_back(r);
    endfunction

    function void check_result(logic [31:0] value, logic [1:0] stat, logic [10:0] total,
                               logic empty, logic full);
      fifo_result_t r;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result: value %h status %0d count %0d", value, stat, total);
        return;
      end
      r = pending_results.pop_front();
      if (value !== r.value || stat !== r.stat || total !== r.total ||
          empty !== r.empty || full !== r.full) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("mismatch: value %h/%h status %0d/%0d count %0d/%0d empty %b/%b full %b/%b",
                   value, r.value, stat, r.stat, total, r.total, empty, r.empty,
                   full, r.full);
      end
    endfunction
  endclass

  logic               clk;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               kind = 1'b0;
  logic signed [31:0] value_in = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] value_out;
  logic [1:0]         status;
  logic [10:0]        total_count;
  logic               is_empty;
  logic               is_full;

  int snd_idle = 0;
  int rcv_idle = 0;

  fifo_scoreboard sb = new();

  spill_fill_cached_fifo_core dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .kind       (kind),
    .value_in   (value_in),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .value_out  (value_out),
    .status     (status),
    .total_count(total_count),
    .is_empty   (is_empty),
    .is_full    (is_full)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < rcv_idle);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_result(value_out, status, total_count, is_empty, is_full);
  end

  // entered and left at a rising edge; valid stays high into the next request
  task automatic send_request(bit op_remove, logic [31:0] word);
    while ($urandom_range(99) < snd_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    kind     <= op_remove;
    value_in <= word;
    do @(posedge clk); while (in_stall);
    sb.note_request(op_remove, word);
  endtask

  // bursts of random length, each with its own insert/remove mix
  task automatic run_mixed(int count);
    int seg_len;
    int insert_pct;
    while (count > 0) begin
      seg_len = $urandom_range(40, 1);
      case ($urandom_range(2))
        0: insert_pct = 90;
        1: insert_pct = 50;
        default: insert_pct = 10;
      endcase
      while (seg_len > 0 && count > 0) begin
        send_request($urandom_range(99) >= insert_pct, $urandom);
        seg_len--;
        count--;
      end
    end
  endtask

  initial begin
    int unsigned drops_target;
    logic [31:0] word;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    snd_idle = 24;
    rcv_idle = 62;

    // directed: remove from empty, extreme values, a spill, then a refill
    send_request(1'b1, 32'h1234_5678);
    for (int i = 0; i < 17; i++) begin
      case (i)
        0: word = 32'h7FFF_FFFF;
        1: word = 32'h8000_0000;
        2: word = 32'h0000_0000;
        3: word = 32'hFFFF_FFFF;
        default: word = $urandom;
      endcase
      send_request(1'b0, word);
    end
    send_request(1'b1, 32'hFFFF_FFFF);
    send_request(1'b1, 32'h0000_0000);

    run_mixed(60);

    // fill until ten inserts have been dropped
    snd_idle = 62;
    rcv_idle = 24;
    drops_target = sb.drops + 10;
    while (sb.drops < drops_target)
      send_request($urandom_range(99) < 3, $urandom);

    // drain most of the store through repeated refills, then mix again
    snd_idle = 0;
    rcv_idle = 0;
    while (sb.level() > 400)
      send_request($urandom_range(99) >= 3, $urandom);
    run_mixed(60);
    in_valid <= 1'b0;

    while (sb.pending() > 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("covered %0d requests with %0d spills, %0d refills, %0d dropped inserts",
             sb.requests, sb.spills, sb.refills, sb.drops);
    $display("and %0d removes from empty, under three idle patterns", sb.underflows);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.mismatches, sb.pending());
      $display("CHECK FAILED");
    end
    $finish;
  end

  // ends the run when nothing moves for too long
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    @(negedge rst);
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("watchdog: no request or result moved for %0d cycles", WATCHDOG_LIMIT);
    $display("CHECK FAILED");
    $finish;
  end

endmodule
